>>> rtl/fvle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fvle_pkg;

    // Default of the texture set limit
    localparam int MAX_TEX_SETS_DEF = 8;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Element type codes
    localparam logic [2:0] TYPE_F1    = 3'd0;
    localparam logic [2:0] TYPE_F2    = 3'd1;
    localparam logic [2:0] TYPE_F3    = 3'd2;
    localparam logic [2:0] TYPE_F4    = 3'd3;
    localparam logic [2:0] TYPE_COLOR = 3'd4;
    localparam logic [2:0] TYPE_UB4   = 3'd5;

    // Element usage codes
    localparam logic [2:0] USAGE_POS     = 3'd0;
    localparam logic [2:0] USAGE_POST    = 3'd1;
    localparam logic [2:0] USAGE_BWEIGHT = 3'd2;
    localparam logic [2:0] USAGE_BINDEX  = 3'd3;
    localparam logic [2:0] USAGE_NORMAL  = 3'd4;
    localparam logic [2:0] USAGE_PSIZE   = 3'd5;
    localparam logic [2:0] USAGE_COLOR   = 3'd6;
    localparam logic [2:0] USAGE_TEX     = 3'd7;

    // Bit positions of the fixed elements in the job mask, in emit order
    localparam int NUM_FIXED = 7;
    localparam logic [2:0] ELEM_POS  = 3'd0;
    localparam logic [2:0] ELEM_WGT  = 3'd1;
    localparam logic [2:0] ELEM_IDX  = 3'd2;
    localparam logic [2:0] ELEM_NRM  = 3'd3;
    localparam logic [2:0] ELEM_PSZ  = 3'd4;
    localparam logic [2:0] ELEM_DIF  = 3'd5;
    localparam logic [2:0] ELEM_SPC  = 3'd6;

    // Texture size codes
    localparam logic [1:0] TEX_SZ_F2 = 2'd0;
    localparam logic [1:0] TEX_SZ_F3 = 2'd1;
    localparam logic [1:0] TEX_SZ_F4 = 2'd2;
    localparam logic [1:0] TEX_SZ_F1 = 2'd3;

    // Classified fixed part of one format code
    typedef struct packed {
        logic [NUM_FIXED-1:0] elem_mask;
        logic                 pos_rhw;
        logic [2:0]           wgt_cnt;
    } job_t;

    function automatic logic [2:0] tex_type(input logic [1:0] sz);
        logic [2:0] t;
        case (sz)
            TEX_SZ_F2: t = TYPE_F2;
            TEX_SZ_F3: t = TYPE_F3;
            TEX_SZ_F4: t = TYPE_F4;
            TEX_SZ_F1: t = TYPE_F1;
            default:   t = TYPE_F2;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] tex_bytes(input logic [1:0] sz);
        logic [4:0] b;
        case (sz)
            TEX_SZ_F2: b = 5'd8;
            TEX_SZ_F3: b = 5'd12;
            TEX_SZ_F4: b = 5'd16;
            TEX_SZ_F1: b = 5'd4;
            default:   b = 5'd8;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fvle_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fvle_front
    import fvle_pkg::*;
#(
    parameter int MAX_TEX_SETS = MAX_TEX_SETS_DEF
)
(
    input  wire logic [31:0]                         format_code,
    output job_t                                     job,
    output logic [$clog2(MAX_TEX_SETS+1)-1:0]        tex_cnt,
    output logic [2*MAX_TEX_SETS-1:0]                tex_sizes
);

    localparam int TEX_CW = $clog2(MAX_TEX_SETS + 1);

    logic [2:0] mode_lo;
    logic       mode_hi;
    logic       is_xyz;
    logic       is_rhw;
    logic       is_blend;
    logic       has_idx;
    logic [2:0] betas;
    logic [2:0] wgt_raw;
    logic [2:0] wgt;
    logic [3:0] tex_raw;

    // Decode the position mode
    always_comb
    begin
        mode_lo  = format_code[3:1];
        mode_hi  = format_code[14];
        is_xyz   = !mode_hi && (mode_lo == 3'd1);
        is_rhw   = !mode_hi && (mode_lo == 3'd2);
        is_blend = !mode_hi && (mode_lo >= 3'd3);
        has_idx  = is_blend && (format_code[12] || format_code[15]);
        betas    = mode_lo - 3'd2;
        wgt_raw  = betas - {2'b00, has_idx};
        wgt      = (wgt_raw > 3'd4) ? 3'd4 : wgt_raw;
    end

    // Build the element mask in emit order
    always_comb
    begin
        job.elem_mask           = '0;
        job.elem_mask[ELEM_POS] = is_xyz || is_rhw || is_blend;
        job.elem_mask[ELEM_WGT] = is_blend && (wgt != 3'd0);
        job.elem_mask[ELEM_IDX] = has_idx;
        job.elem_mask[ELEM_NRM] = format_code[4] && !is_rhw;
        job.elem_mask[ELEM_PSZ] = format_code[5];
        job.elem_mask[ELEM_DIF] = format_code[6];
        job.elem_mask[ELEM_SPC] = format_code[7];
        job.pos_rhw             = is_rhw;
        job.wgt_cnt             = wgt;
    end

    // Cap the texture set count and pick out the size codes
    always_comb
    begin
        tex_raw = format_code[11:8];
        if (tex_raw > 4'(MAX_TEX_SETS))
        begin
            tex_cnt = TEX_CW'(MAX_TEX_SETS);
        end
        else
        begin
            tex_cnt = TEX_CW'(tex_raw);
        end
        tex_sizes = format_code[16 +: 2*MAX_TEX_SETS];
    end

endmodule

`default_nettype wire

>>> rtl/fvle_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fvle_queue
    import fvle_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fvle_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fvle_back
    import fvle_pkg::*;
#(
    parameter int MAX_TEX_SETS = MAX_TEX_SETS_DEF
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  q_valid,
    output logic                                       q_ready,
    input  wire job_t                                  q_job,
    input  wire logic [$clog2(MAX_TEX_SETS+1)-1:0]     q_tex_cnt,
    input  wire logic [2*MAX_TEX_SETS-1:0]             q_tex_sizes,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [2:0]                                 elem_type,
    output logic [2:0]                                 elem_usage,
    output logic [2:0]                                 usage_slot,
    output logic [7:0]                                 byte_offset,
    output logic                                       is_end
);

    localparam int TEX_CW = $clog2(MAX_TEX_SETS + 1);

    logic                    busy_reg, busy_next;
    logic [NUM_FIXED-1:0]    mask_reg, mask_next;
    logic                    pos_rhw_reg, pos_rhw_next;
    logic [2:0]              wgt_cnt_reg, wgt_cnt_next;
    logic [TEX_CW-1:0]       tex_cnt_reg, tex_cnt_next;
    logic [TEX_CW-1:0]       tex_idx_reg, tex_idx_next;
    logic [2*MAX_TEX_SETS-1:0] tex_sizes_reg, tex_sizes_next;
    logic [7:0]              offset_reg, offset_next;

    logic                    out_valid_reg, out_valid_next;
    logic [2:0]              out_type_reg, out_type_next;
    logic [2:0]              out_usage_reg, out_usage_next;
    logic [2:0]              out_slot_reg, out_slot_next;
    logic [7:0]              out_offset_reg, out_offset_next;
    logic                    out_end_reg, out_end_next;

    logic                    adv;
    logic                    has_fixed;
    logic                    has_tex;
    logic                    at_end;
    logic                    load;
    logic [2:0]              sel;
    logic [2:0]              e_type;
    logic [2:0]              e_usage;
    logic [2:0]              e_slot;
    logic [4:0]              e_size;
    logic [1:0]              tex_sz;

    assign out_valid   = out_valid_reg;
    assign elem_type   = out_type_reg;
    assign elem_usage  = out_usage_reg;
    assign usage_slot  = out_slot_reg;
    assign byte_offset = out_offset_reg;
    assign is_end      = out_end_reg;

    // Output register advances when empty or taken
    assign adv       = !out_valid_reg || out_ready;
    assign has_fixed = (mask_reg != '0);
    assign has_tex   = (tex_idx_reg < tex_cnt_reg);
    assign at_end    = busy_reg && !has_fixed && !has_tex;
    assign q_ready   = adv && (!busy_reg || at_end);
    assign load      = q_valid && q_ready;
    assign tex_sz    = tex_sizes_reg[1:0];

    // Pick the lowest pending fixed element
    always_comb
    begin
        sel = ELEM_POS;
        for (int i = NUM_FIXED - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = 3'(i);
            end
        end
    end

    // Describe the element to emit
    always_comb
    begin
        e_type  = TYPE_F1;
        e_usage = USAGE_POS;
        e_slot  = 3'd0;
        e_size  = 5'd0;
        if (has_fixed)
        begin
            case (sel)
                ELEM_POS:
                begin
                    e_type  = pos_rhw_reg ? TYPE_F4 : TYPE_F3;
                    e_usage = pos_rhw_reg ? USAGE_POST : USAGE_POS;
                    e_size  = pos_rhw_reg ? 5'd16 : 5'd12;
                end
                ELEM_WGT:
                begin
                    e_type  = wgt_cnt_reg - 3'd1;
                    e_usage = USAGE_BWEIGHT;
                    e_size  = {wgt_cnt_reg, 2'b00};
                end
                ELEM_IDX:
                begin
                    e_type  = TYPE_UB4;
                    e_usage = USAGE_BINDEX;
                    e_size  = 5'd4;
                end
                ELEM_NRM:
                begin
                    e_type  = TYPE_F3;
                    e_usage = USAGE_NORMAL;
                    e_size  = 5'd12;
                end
                ELEM_PSZ:
                begin
                    e_type  = TYPE_F1;
                    e_usage = USAGE_PSIZE;
                    e_size  = 5'd4;
                end
                ELEM_DIF:
                begin
                    e_type  = TYPE_COLOR;
                    e_usage = USAGE_COLOR;
                    e_size  = 5'd4;
                end
                ELEM_SPC:
                begin
                    e_type  = TYPE_COLOR;
                    e_usage = USAGE_COLOR;
                    e_slot  = 3'd1;
                    e_size  = 5'd4;
                end
                default:
                begin
                    e_type  = TYPE_F1;
                    e_usage = USAGE_POS;
                end
            endcase
        end
        else
        begin
            e_type  = tex_type(tex_sz);
            e_usage = USAGE_TEX;
            e_slot  = 3'(tex_idx_reg);
            e_size  = tex_bytes(tex_sz);
        end
    end

    // Sequence the job and fill the output register
    always_comb
    begin
        busy_next       = busy_reg;
        mask_next       = mask_reg;
        pos_rhw_next    = pos_rhw_reg;
        wgt_cnt_next    = wgt_cnt_reg;
        tex_cnt_next    = tex_cnt_reg;
        tex_idx_next    = tex_idx_reg;
        tex_sizes_next  = tex_sizes_reg;
        offset_next     = offset_reg;
        out_valid_next  = out_valid_reg;
        out_type_next   = out_type_reg;
        out_usage_next  = out_usage_reg;
        out_slot_next   = out_slot_reg;
        out_offset_next = out_offset_reg;
        out_end_next    = out_end_reg;

        if (adv)
        begin
            out_valid_next = busy_reg;
            if (busy_reg)
            begin
                if (at_end)
                begin
                    out_type_next   = TYPE_F1;
                    out_usage_next  = USAGE_POS;
                    out_slot_next   = 3'd0;
                    out_offset_next = 8'd0;
                    out_end_next    = 1'b1;
                    busy_next       = 1'b0;
                end
                else
                begin
                    out_type_next   = e_type;
                    out_usage_next  = e_usage;
                    out_slot_next   = e_slot;
                    out_offset_next = offset_reg;
                    out_end_next    = 1'b0;
                    offset_next     = offset_reg + 8'(e_size);
                    if (has_fixed)
                    begin
                        mask_next = mask_reg & (mask_reg - 1'b1);
                    end
                    else
                    begin
                        tex_idx_next   = tex_idx_reg + 1'b1;
                        tex_sizes_next = tex_sizes_reg >> 2;
                    end
                end
            end
        end

        // Take the next job from the queue
        if (load)
        begin
            busy_next      = 1'b1;
            mask_next      = q_job.elem_mask;
            pos_rhw_next   = q_job.pos_rhw;
            wgt_cnt_next   = q_job.wgt_cnt;
            tex_cnt_next   = q_tex_cnt;
            tex_idx_next   = '0;
            tex_sizes_next = q_tex_sizes;
            offset_next    = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg       <= mask_next;
        pos_rhw_reg    <= pos_rhw_next;
        wgt_cnt_reg    <= wgt_cnt_next;
        tex_cnt_reg    <= tex_cnt_next;
        tex_idx_reg    <= tex_idx_next;
        tex_sizes_reg  <= tex_sizes_next;
        offset_reg     <= offset_next;
        out_type_reg   <= out_type_next;
        out_usage_reg  <= out_usage_next;
        out_slot_reg   <= out_slot_next;
        out_offset_reg <= out_offset_next;
        out_end_reg    <= out_end_next;
    end

endmodule

`default_nettype wire

>>> rtl/fvf_vertex_layout_expander_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Vertex layout expander. Each word taken on the s_ side is a 32-bit flexible
// vertex format code; the m_ side returns one word per vertex element that
// the code describes (position, blend weights and indices, normal, point
// size, diffuse, specular, then up to MAX_TEX_SETS texture sets), each with
// its running byte offset, followed by an end word flagged by m_tlast. A
// format code yields between one and sixteen words. The back-end sequencer
// emits one word per cycle unless the output stalls, and takes the next code
// from the queue as it emits the current code's end word. A two-entry job
// queue after the decoder lets the input side take up to two further codes
// while the sequencer is busy or the output is stalled. No configuration and
// no clearing pass: the input can take a word as soon as reset is released.
module fvf_vertex_layout_expander_unit
    import fvle_pkg::*;
#(
    parameter int MAX_TEX_SETS = MAX_TEX_SETS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] format_code
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] elem_type, [5:3] elem_usage,
                                        // [8:6] usage_slot, [16:9] byte_offset,
                                        // [23:17] zero
    output logic             m_tlast    // is_end
);

    localparam int TEX_CW = $clog2(MAX_TEX_SETS + 1);
    localparam int TEX_SW = 2 * MAX_TEX_SETS;
    localparam int JOB_W  = $bits(job_t) + TEX_CW + TEX_SW;

    job_t              f_job;
    logic [TEX_CW-1:0] f_tex_cnt;
    logic [TEX_SW-1:0] f_tex_sizes;

    logic              q_pop_valid;
    logic              q_pop_ready;
    logic [JOB_W-1:0]  q_pop_data;
    job_t              q_job;
    logic [TEX_CW-1:0] q_tex_cnt;
    logic [TEX_SW-1:0] q_tex_sizes;

    logic [2:0]        elem_type;
    logic [2:0]        elem_usage;
    logic [2:0]        usage_slot;
    logic [7:0]        byte_offset;
    logic              is_end;

    // Classify the incoming format code
    fvle_front #(
        .MAX_TEX_SETS (MAX_TEX_SETS)
    ) u_front (
        .format_code (s_tdata),
        .job         (f_job),
        .tex_cnt     (f_tex_cnt),
        .tex_sizes   (f_tex_sizes)
    );

    // Hold classified jobs until the sequencer takes them
    fvle_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  ({f_tex_sizes, f_tex_cnt, f_job}),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    assign {q_tex_sizes, q_tex_cnt, q_job} = q_pop_data;

    // Walk the elements of each job
    fvle_back #(
        .MAX_TEX_SETS (MAX_TEX_SETS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_pop_valid),
        .q_ready     (q_pop_ready),
        .q_job       (q_job),
        .q_tex_cnt   (q_tex_cnt),
        .q_tex_sizes (q_tex_sizes),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .elem_type   (elem_type),
        .elem_usage  (elem_usage),
        .usage_slot  (usage_slot),
        .byte_offset (byte_offset),
        .is_end      (is_end)
    );

    assign m_tdata = {7'd0, byte_offset, usage_slot, elem_usage, elem_type};
    assign m_tlast = is_end;

    // End word carries all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[16:0] == 17'd0)
        else $error("end word has nonzero fields");

    // Pretransformed position is always the first element
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast && m_tdata[5:3] == USAGE_POST |-> m_tdata[16:9] == 8'd0)
        else $error("pretransformed position not at offset zero");

    // Offsets stay within the largest possible vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16:9] <= 8'd184)
        else $error("byte offset out of range");

    // Input stalls only when the job queue holds work
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_pop_valid)
        else $error("input stalled with empty job queue");

endmodule

`default_nettype wire
